// ===== src/dbel_pkg.sv =====
// ----------------------------------------------------------------------------
// dbel_pkg
// Shared constants, codes and types of the integrating debounce bank.
// ----------------------------------------------------------------------------
`default_nettype none

package dbel_pkg;

  // Bank geometry.
  localparam int CHANNELS     = 32;
  localparam int COUNTER_BITS = 4;

  // Fixed field widths.
  localparam int RAW_W    = 32;
  localparam int CH_W     = 5;
  localparam int LEVEL_W  = 32;
  localparam int MASK_W   = 32;
  localparam int FILTER_W = 4;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Counter values are compared against 4-bit registers at a common width.
  localparam int CMP_W = (COUNTER_BITS > FILTER_W) ? COUNTER_BITS : FILTER_W;
  localparam logic [CMP_W-1:0] CNT_LIMIT = CMP_W'((1 << COUNTER_BITS) - 1);

  // Channels that are visible in the debounced level word.
  localparam int VISIBLE = (CHANNELS < LEVEL_W) ? CHANNELS : LEVEL_W;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_READ_LEVEL = 2'd1,
    OP_READ_RISE  = 2'd2,
    OP_READ_FALL  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_LOW_MASK = 2'd0,
    REG_FILTER_MAX      = 2'd1,
    REG_LEVEL_THRESHOLD = 2'd2
  } reg_idx_t;

  // Control handed from the top level to the counter bank.
  typedef struct packed {
    logic             tick;
    logic [CMP_W-1:0] top;
    logic [CMP_W-1:0] threshold;
  } bank_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dbel_in_if.sv =====
// ----------------------------------------------------------------------------
// dbel_in_if
// Request channel: operation, raw pin levels and queried channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbel_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [dbel_pkg::RAW_W-1:0] raw_levels;
  logic [dbel_pkg::CH_W-1:0]  channel;

  modport source (output valid, output operation, output raw_levels, output channel,
                  input ready);
  modport sink (input valid, input operation, input raw_levels, input channel,
                output ready);
endinterface

`default_nettype wire

// ===== src/dbel_out_if.sv =====
// ----------------------------------------------------------------------------
// dbel_out_if
// Result channel: queried bit and the debounced level word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbel_out_if;
  logic                         valid;
  logic                         ready;
  logic                         flag_bit;
  logic [dbel_pkg::LEVEL_W-1:0] debounced_levels;

  modport source (output valid, output flag_bit, output debounced_levels, input ready);
  modport sink (input valid, input flag_bit, input debounced_levels, output ready);
endinterface

`default_nettype wire

// ===== src/dbel_counter_bank.sv =====
// ----------------------------------------------------------------------------
// dbel_counter_bank
// One saturating integrator counter per channel, with the level compare.
// ----------------------------------------------------------------------------
`default_nettype none

module dbel_counter_bank (
  input  wire                                  clk,
  input  wire                                  rst,
  input  dbel_pkg::bank_ctrl_t                 ctrl,
  input  wire  [dbel_pkg::CHANNELS-1:0]        asserted,
  output logic [dbel_pkg::CHANNELS-1:0]        level_next
);

  logic [dbel_pkg::COUNTER_BITS-1:0] count      [dbel_pkg::CHANNELS];
  logic [dbel_pkg::COUNTER_BITS-1:0] count_next [dbel_pkg::CHANNELS];

  for (genvar i = 0; i < dbel_pkg::CHANNELS; i++) begin : g_chan
    logic [dbel_pkg::CMP_W-1:0] count_ext;

    // A counter left above the top by a lowered filter_max only holds when
    // asserted, and still counts down when deasserted.
    always_comb begin
      count_ext     = dbel_pkg::CMP_W'(count[i]);
      count_next[i] = count[i];
      if (asserted[i]) begin
        if (count_ext < ctrl.top) begin
          count_next[i] = count[i] + 1'b1;
        end
      end else if (count[i] != '0) begin
        count_next[i] = count[i] - 1'b1;
      end
      level_next[i] = dbel_pkg::CMP_W'(count_next[i]) >= ctrl.threshold;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        count[i] <= '0;
      end else if (ctrl.tick) begin
        count[i] <= count_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/integrating_debounce_edge_latch_bank_top.sv =====
// Path: an accepted word is held in the input register, and its result is then registered in the result register.
// Throughput: one word per cycle; the input register refills while the result
// register is taken, and only a stalled result register with a full input stage stops input.
// Reset: synchronous and active high; counters, levels, edge flags and both valid
// bits clear, and the configuration registers return to their reset values.
`default_nettype none
// ----------------------------------------------------------------------------
// integrating_debounce_edge_latch_bank_top
// Bank of integrating debounce counters with sticky rising and falling flags.
// ----------------------------------------------------------------------------

module integrating_debounce_edge_latch_bank_top (
  input  wire                                 clk,
  input  wire                                 rst,
  dbel_in_if.sink                             in_words,
  dbel_out_if.source                          out_words,
  input  wire                                 cfg_wr_en,
  input  wire  [dbel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [dbel_pkg::CFG_W-1:0]          cfg_data
);

  // Configuration registers.
  logic [dbel_pkg::MASK_W-1:0]   active_low_mask;
  logic [dbel_pkg::FILTER_W-1:0] filter_max;
  logic [dbel_pkg::FILTER_W-1:0] level_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low_mask <= dbel_pkg::MASK_W'(32'h3000_000F);
      filter_max      <= dbel_pkg::FILTER_W'(6);
      level_threshold <= dbel_pkg::FILTER_W'(4);
    end else if (cfg_wr_en) begin
      case (dbel_pkg::reg_idx_t'(cfg_index))
        dbel_pkg::REG_ACTIVE_LOW_MASK: active_low_mask <= cfg_data[dbel_pkg::MASK_W-1:0];
        dbel_pkg::REG_FILTER_MAX:      filter_max      <= cfg_data[dbel_pkg::FILTER_W-1:0];
        dbel_pkg::REG_LEVEL_THRESHOLD: level_threshold <= cfg_data[dbel_pkg::FILTER_W-1:0];
        default: ;
      endcase
    end
  end

  // Input stage. A word sits here until the result register can take its
  // result; the state update happens in the same cycle as that transfer, so
  // words are applied strictly in order.
  logic                         stage_valid;
  dbel_pkg::op_t                stage_op;
  logic [dbel_pkg::RAW_W-1:0]   stage_raw;
  logic [dbel_pkg::CH_W-1:0]    stage_channel;

  logic                         out_valid;
  logic                         out_flag;
  logic [dbel_pkg::LEVEL_W-1:0] out_levels;

  logic advance;
  logic in_take;

  assign advance        = stage_valid && (!out_valid || out_words.ready);
  assign in_words.ready = !stage_valid || advance;
  assign in_take        = in_words.valid && in_words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_words.ready) begin
      stage_valid <= in_words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_op      <= dbel_pkg::op_t'(in_words.operation);
      stage_raw     <= in_words.raw_levels;
      stage_channel <= in_words.channel;
    end
  end

  // Per-channel assertion: polarity from the mask; channels beyond the raw
  // word never see an asserted level.
  logic [dbel_pkg::CHANNELS-1:0] asserted;
  logic [dbel_pkg::CHANNELS-1:0] channel_sel;

  for (genvar i = 0; i < dbel_pkg::CHANNELS; i++) begin : g_decode
    if (i < dbel_pkg::RAW_W) begin : g_low
      assign asserted[i]    = stage_raw[i] ^ active_low_mask[i];
      assign channel_sel[i] = stage_channel == dbel_pkg::CH_W'(i);
    end else begin : g_high
      assign asserted[i]    = 1'b0;
      assign channel_sel[i] = 1'b0;
    end
  end

  // Counter bank: counters move only when a sample tick leaves the stage.
  dbel_pkg::bank_ctrl_t          bank_ctrl;
  logic [dbel_pkg::CHANNELS-1:0] level_next;
  logic                          tick;

  assign tick = advance && (stage_op == dbel_pkg::OP_TICK);

  always_comb begin
    bank_ctrl.tick      = tick;
    bank_ctrl.top       = (dbel_pkg::CMP_W'(filter_max) > dbel_pkg::CNT_LIMIT)
                          ? dbel_pkg::CNT_LIMIT : dbel_pkg::CMP_W'(filter_max);
    bank_ctrl.threshold = dbel_pkg::CMP_W'(level_threshold);
  end

  dbel_counter_bank u_bank (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (bank_ctrl),
    .asserted   (asserted),
    .level_next (level_next)
  );

  // Debounced levels and sticky edge flags.
  logic [dbel_pkg::CHANNELS-1:0] level_bits;
  logic [dbel_pkg::CHANNELS-1:0] rise_flags;
  logic [dbel_pkg::CHANNELS-1:0] fall_flags;
  logic [dbel_pkg::CHANNELS-1:0] level_bits_next;
  logic [dbel_pkg::CHANNELS-1:0] rise_flags_next;
  logic [dbel_pkg::CHANNELS-1:0] fall_flags_next;
  logic                          flag_next;

  always_comb begin
    level_bits_next = level_bits;
    rise_flags_next = rise_flags;
    fall_flags_next = fall_flags;
    flag_next       = 1'b0;
    case (stage_op)
      dbel_pkg::OP_TICK: begin
        level_bits_next = level_next;
        rise_flags_next = rise_flags | (level_next & ~level_bits);
        fall_flags_next = fall_flags | (level_bits & ~level_next);
      end
      dbel_pkg::OP_READ_LEVEL: begin
        flag_next = |(level_bits & channel_sel);
      end
      dbel_pkg::OP_READ_RISE: begin
        flag_next       = |(rise_flags & channel_sel);
        rise_flags_next = rise_flags & ~channel_sel;
      end
      dbel_pkg::OP_READ_FALL: begin
        flag_next       = |(fall_flags & channel_sel);
        fall_flags_next = fall_flags & ~channel_sel;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_bits <= '0;
      rise_flags <= '0;
      fall_flags <= '0;
    end else if (advance) begin
      level_bits <= level_bits_next;
      rise_flags <= rise_flags_next;
      fall_flags <= fall_flags_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_words.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_flag   <= flag_next;
      out_levels <= dbel_pkg::LEVEL_W'(level_bits_next[dbel_pkg::VISIBLE-1:0]);
    end
  end

  assign out_words.valid            = out_valid;
  assign out_words.flag_bit         = out_flag;
  assign out_words.debounced_levels = out_levels;

`ifndef ASSERT_OFF
  // The level word handed out always matches the level state it came from.
  a_levels_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_levels == dbel_pkg::LEVEL_W'(level_bits[dbel_pkg::VISIBLE-1:0]))
    else $error("result level word differs from the level state");

  // A read of a rising flag leaves that flag clear.
  a_rise_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && stage_op == dbel_pkg::OP_READ_RISE |=> (rise_flags & $past(channel_sel)) == '0)
    else $error("rising flag survived its read");

  // Input is refused only when the stage is full and its result cannot move on.
  a_refuse_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_words.ready |-> stage_valid && out_valid && !out_words.ready)
    else $error("input refused without a blocked result");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/integrating_debounce_edge_latch_bank_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integrating_debounce_edge_latch_bank_top_tb
// Self-checking bench for the debounce bank. A short table of directed words
// runs first. Random phases follow, each with its own register setting. A
// cycle-level predictor tracks counters, levels and sticky flags and checks
// every result word in order.
// ----------------------------------------------------------------------------

module integrating_debounce_edge_latch_bank_top_tb;

  localparam int RANDOM_PHASES   = 9;
  localparam int WORDS_PER_PHASE = 200;
  localparam int HOLD_OFF_EVERY  = 1500;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int DIRECTED_WORDS  = 25;

  localparam logic [dbel_pkg::LEVEL_W-1:0] RESET_MASK_LEVELS = 32'h3000_000F;
  localparam logic [dbel_pkg::LEVEL_W-1:0] OTHER_LEVELS      = 32'hCFFF_FFF0;

  typedef struct packed {
    logic                         flag_bit;
    logic [dbel_pkg::LEVEL_W-1:0] debounced_levels;
  } debounce_result_t;

  // One request word, with an optional hand-written expectation.
  typedef struct {
    dbel_pkg::op_t                op;
    logic [dbel_pkg::RAW_W-1:0]   raw;
    logic [dbel_pkg::CH_W-1:0]    ch;
    bit                           typed;
    logic                         typed_flag;
    logic [dbel_pkg::LEVEL_W-1:0] typed_levels;
  } stim_word_t;

  typedef struct {
    logic [dbel_pkg::MASK_W-1:0]   mask;
    logic [dbel_pkg::FILTER_W-1:0] top;
    logic [dbel_pkg::FILTER_W-1:0] threshold;
    bit                            pick_random;
  } cfg_setting_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_wr_en;
  dbel_pkg::reg_idx_t         cfg_index;
  logic [dbel_pkg::CFG_W-1:0] cfg_data;

  // Hand-written expectation travelling alongside the request word.
  logic                         word_typed;
  logic                         word_typed_flag;
  logic [dbel_pkg::LEVEL_W-1:0] word_typed_levels;

  dbel_in_if  in_words();
  dbel_out_if out_words();

  integrating_debounce_edge_latch_bank_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_words  (in_words),
    .out_words (out_words),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the counters, flags and registers.
  // --------------------------------------------------------------------------
  logic [dbel_pkg::COUNTER_BITS-1:0] integ_count [dbel_pkg::CHANNELS];
  logic [dbel_pkg::CHANNELS-1:0]     level_word;
  logic [dbel_pkg::CHANNELS-1:0]     rise_word;
  logic [dbel_pkg::CHANNELS-1:0]     fall_word;
  logic [dbel_pkg::MASK_W-1:0]       pol_mask;
  logic [dbel_pkg::FILTER_W-1:0]     top_reg;
  logic [dbel_pkg::FILTER_W-1:0]     thr_reg;

  debounce_result_t           pending_results[$];
  int unsigned                mismatch_count;
  int unsigned                result_index;
  int unsigned                quiet_cycles;
  int unsigned                burst_left;
  logic [dbel_pkg::RAW_W-1:0] pin_state;

  // A tick moves every counter at most one step toward its asserted or deasserted end,
  // then the threshold decides the new level word and edges set sticky flags.
  // Reads return a bit from before the clear.
  task automatic debounce_apply(input dbel_pkg::op_t op,
                                input logic [dbel_pkg::RAW_W-1:0] raw,
                                input logic [dbel_pkg::CH_W-1:0] ch,
                                output debounce_result_t res);
    int unsigned                   top;
    int unsigned                   cnt;
    logic                          asserted;
    logic [dbel_pkg::CHANNELS-1:0] new_level;
    res       = '0;
    new_level = '0;
    if (op == dbel_pkg::OP_TICK) begin
      top = top_reg;
      if (top > (1 << dbel_pkg::COUNTER_BITS) - 1) top = (1 << dbel_pkg::COUNTER_BITS) - 1;
      for (int i = 0; i < dbel_pkg::CHANNELS; i++) begin
        asserted = raw[i] ^ pol_mask[i];
        cnt      = integ_count[i];
        // A counter left above a lowered top holds there while asserted.
        if (asserted) begin
          if (cnt < top) cnt++;
        end else if (cnt > 0) begin
          cnt--;
        end
        integ_count[i] = dbel_pkg::COUNTER_BITS'(cnt);
        new_level[i]   = (cnt >= thr_reg);
      end
      rise_word  = rise_word | (new_level & ~level_word);
      fall_word  = fall_word | (level_word & ~new_level);
      level_word = new_level;
    end else if (ch < dbel_pkg::CHANNELS) begin
      case (op)
        dbel_pkg::OP_READ_LEVEL: res.flag_bit = level_word[ch];
        dbel_pkg::OP_READ_RISE: begin
          res.flag_bit  = rise_word[ch];
          rise_word[ch] = 1'b0;
        end
        default: begin
          res.flag_bit  = fall_word[ch];
          fall_word[ch] = 1'b0;
        end
      endcase
    end
    res.debounced_levels = level_word[dbel_pkg::LEVEL_W-1:0];
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what,
                                 input logic [dbel_pkg::LEVEL_W-1:0] got,
                                 input logic [dbel_pkg::LEVEL_W-1:0] want);
    $display("MISMATCH at %0t, result %0d, %s: got %h, want %h",
             $time, result_index, what, got, want);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: checks result words, predicts accepted request words and
  // follows register writes, all on the same edge in one process.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : track
    debounce_result_t oldest;
    debounce_result_t predicted;
    if (rst) begin
      for (int i = 0; i < dbel_pkg::CHANNELS; i++) integ_count[i] = '0;
      level_word = '0;
      rise_word  = '0;
      fall_word  = '0;
      pol_mask   = RESET_MASK_LEVELS;
      top_reg    = dbel_pkg::FILTER_W'(6);
      thr_reg    = dbel_pkg::FILTER_W'(4);
      pending_results.delete();
    end else begin
      // The result side is checked before the request side so that a result
      // can never match a word accepted on the same edge.
      if (out_words.valid && out_words.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending",
                          out_words.debounced_levels, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (out_words.flag_bit !== oldest.flag_bit)
            report_mismatch("flag_bit", dbel_pkg::LEVEL_W'(out_words.flag_bit),
                            dbel_pkg::LEVEL_W'(oldest.flag_bit));
          if (out_words.debounced_levels !== oldest.debounced_levels)
            report_mismatch("debounced_levels", out_words.debounced_levels,
                            oldest.debounced_levels);
        end
        result_index++;
      end
      if (in_words.valid && in_words.ready) begin
        debounce_apply(dbel_pkg::op_t'(in_words.operation), in_words.raw_levels,
                       in_words.channel, predicted);
        if (word_typed) begin
          predicted.flag_bit         = word_typed_flag;
          predicted.debounced_levels = word_typed_levels;
        end
        pending_results.push_back(predicted);
      end
      // Register writes only change the setting; levels wait for the next tick.
      if (cfg_wr_en) begin
        case (cfg_index)
          dbel_pkg::REG_ACTIVE_LOW_MASK: pol_mask = cfg_data[dbel_pkg::MASK_W-1:0];
          dbel_pkg::REG_FILTER_MAX:      top_reg  = cfg_data[dbel_pkg::FILTER_W-1:0];
          dbel_pkg::REG_LEVEL_THRESHOLD: thr_reg  = cfg_data[dbel_pkg::FILTER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (in_words.valid && in_words.ready) || (out_words.valid && out_words.ready)
        || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("integrating_debounce_edge_latch_bank_top_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: segments of differing ready density, including fully
  // ready stretches, with a long hold-off every so often so that the block
  // fills up and stalls its input while the sender keeps offering words.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned seg_len;
    int unsigned mode;
    int unsigned cycle_no;
    out_words.ready <= 1'b0;
    cycle_no = 0;
    forever begin
      seg_len = $urandom_range(4, 40);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        cycle_no++;
        if (cycle_no % HOLD_OFF_EVERY == 0) begin
          out_words.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       out_words.ready <= 1'b1;
          1:       out_words.ready <= ($urandom_range(0, 1) == 0);
          2:       out_words.ready <= ($urandom_range(0, 9) != 0);
          default: out_words.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender.
  // --------------------------------------------------------------------------

  // Offers one word and returns at the edge where it is taken. Words come in
  // bursts; between bursts valid drops for a random gap, sometimes none.
  task automatic send_word(input stim_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_words.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_words.valid      <= 1'b1;
    in_words.operation  <= w.op;
    in_words.raw_levels <= w.raw;
    in_words.channel    <= w.ch;
    word_typed          <= w.typed;
    word_typed_flag     <= w.typed_flag;
    word_typed_levels   <= w.typed_levels;
    do @(posedge clk); while (!in_words.ready);
  endtask

  // Drops valid and waits until every result word has come back.
  task automatic wait_idle();
    in_words.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input dbel_pkg::reg_idx_t idx,
                           input logic [dbel_pkg::CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Directed words under the reset setting (low-active channels 0-3, 28, 29,
  // top 6, threshold 4). Typed rows follow the counters by hand: four low
  // ticks raise the low-active channels, saturation holds them at six, and
  // all-high ticks then swap which group is up.
  stim_word_t directed_words [DIRECTED_WORDS] = '{
    '{dbel_pkg::OP_READ_LEVEL, 32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_READ_RISE,  32'h0000_0000, 5'd31, 1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_READ_FALL,  32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_READ_RISE,  32'h0000_0000, 5'd0,  1'b1, 1'b1, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_READ_RISE,  32'h0000_0000, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_READ_LEVEL, 32'h0000_0000, 5'd29, 1'b1, 1'b1, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_READ_LEVEL, 32'h0000_0000, 5'd31, 1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_TICK,       32'h0000_0000, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_TICK,       32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_TICK,       32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, RESET_MASK_LEVELS},
    '{dbel_pkg::OP_TICK,       32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_READ_FALL,  32'h0000_0000, 5'd3,  1'b1, 1'b1, 32'h0},
    '{dbel_pkg::OP_READ_FALL,  32'h0000_0000, 5'd3,  1'b1, 1'b0, 32'h0},
    '{dbel_pkg::OP_TICK,       32'hFFFF_FFFF, 5'd0,  1'b1, 1'b0, OTHER_LEVELS},
    '{dbel_pkg::OP_READ_RISE,  32'h0000_0000, 5'd31, 1'b1, 1'b1, OTHER_LEVELS},
    '{dbel_pkg::OP_READ_RISE,  32'h0000_0000, 5'd28, 1'b1, 1'b1, OTHER_LEVELS},
    '{dbel_pkg::OP_READ_FALL,  32'h0000_0000, 5'd31, 1'b1, 1'b0, OTHER_LEVELS},
    '{dbel_pkg::OP_TICK,       32'hA5A5_A5A5, 5'd0,  1'b0, 1'b0, 32'h0},
    '{dbel_pkg::OP_READ_LEVEL, 32'h0000_0000, 5'd16, 1'b0, 1'b0, 32'h0}
  };

  // Register settings of the random phases. The second phase lowers the top
  // under counters that sat at fifteen; later ones cover a zero top and a
  // zero threshold.
  cfg_setting_t phase_settings [RANDOM_PHASES] = '{
    '{32'h0000_0000, 4'd15, 4'd15, 1'b0},
    '{32'h0000_0000, 4'd2,  4'd1,  1'b0},
    '{32'hFFFF_FFFF, 4'd1,  4'd1,  1'b0},
    '{32'h5A5A_5A5A, 4'd0,  4'd3,  1'b0},
    '{32'h0F0F_0F0F, 4'd5,  4'd0,  1'b0},
    '{32'h0000_0000, 4'd0,  4'd0,  1'b1},
    '{32'h3000_000F, 4'd6,  4'd4,  1'b0},
    '{32'h0000_0000, 4'd0,  4'd0,  1'b1},
    '{32'h0000_0000, 4'd0,  4'd0,  1'b1}
  };

  initial begin : stimulus
    stim_word_t                 w;
    cfg_setting_t               setting;
    logic [dbel_pkg::CFG_W-1:0] low_nibble_only;
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= dbel_pkg::REG_ACTIVE_LOW_MASK;
    cfg_data            <= '0;
    in_words.valid      <= 1'b0;
    in_words.operation  <= dbel_pkg::OP_TICK;
    in_words.raw_levels <= '0;
    in_words.channel    <= '0;
    word_typed          <= 1'b0;
    word_typed_flag     <= 1'b0;
    word_typed_levels   <= '0;
    mismatch_count  = 0;
    result_index    = 0;
    burst_left      = 0;
    pin_state       = $urandom;
    low_nibble_only = dbel_pkg::CFG_W'({dbel_pkg::FILTER_W{1'b1}});
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) send_word(directed_words[i]);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setting = phase_settings[p];
      if (setting.pick_random) begin
        setting.mask      = $urandom;
        setting.top       = dbel_pkg::FILTER_W'($urandom_range(1, 15));
        setting.threshold = dbel_pkg::FILTER_W'($urandom_range(1, setting.top));
      end
      wait_idle();
      // Upper data bits of the narrow registers carry noise the block must drop.
      write_reg(dbel_pkg::REG_ACTIVE_LOW_MASK, dbel_pkg::CFG_W'(setting.mask));
      write_reg(dbel_pkg::REG_FILTER_MAX,
                (dbel_pkg::CFG_W'($urandom) & ~low_nibble_only)
                | dbel_pkg::CFG_W'(setting.top));
      write_reg(dbel_pkg::REG_LEVEL_THRESHOLD,
                (dbel_pkg::CFG_W'($urandom) & ~low_nibble_only)
                | dbel_pkg::CFG_W'(setting.threshold));
      cfg_wr_en <= 1'b0;

      // Ticks mostly follow a slowly changing pin pattern so that counters
      // reach their ends and levels really toggle; some ticks glitch one pin
      // and a few are pure noise. Reads pick any channel.
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w.typed        = 1'b0;
        w.typed_flag   = 1'b0;
        w.typed_levels = '0;
        w.ch           = dbel_pkg::CH_W'($urandom_range(0, (1 << dbel_pkg::CH_W) - 1));
        if ($urandom_range(0, 9) < 5) begin
          w.op = dbel_pkg::OP_TICK;
          if ($urandom_range(0, 2) == 0)
            pin_state = pin_state
                        ^ (dbel_pkg::RAW_W'(1) << $urandom_range(0, dbel_pkg::RAW_W - 1));
          if ($urandom_range(0, 39) == 0)
            pin_state = pin_state ^ dbel_pkg::RAW_W'($urandom);
          if ($urandom_range(0, 7) == 0)
            w.raw = $urandom;
          else if ($urandom_range(0, 3) == 0)
            w.raw = pin_state
                    ^ (dbel_pkg::RAW_W'(1) << $urandom_range(0, dbel_pkg::RAW_W - 1));
          else
            w.raw = pin_state;
        end else begin
          w.op  = dbel_pkg::op_t'($urandom_range(1, 3));
          w.raw = $urandom;
        end
        send_word(w);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("integrating_debounce_edge_latch_bank_top_tb OK");
    end else begin
      $display("integrating_debounce_edge_latch_bank_top_tb NOT OK");
    end
    $finish;
  end

endmodule
